@@ rtl/jmi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmi_pkg: shared types and constants for the joint motion integrator
// Field widths, request kinds, joint modes and fixed-point constants.
// ----------------------------------------------------------------------------
package jmi_pkg;

    localparam int MAX_JOINTS_DEF = 8;
    localparam int VAL_W          = 32;
    localparam int DT_W           = 10;
    localparam int KIND_W         = 3;
    localparam int JNT_W          = 3;
    localparam int CNT_W          = 4;
    localparam int MODE_W         = 2;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TARGET = 3'd1;
    localparam logic [KIND_W-1:0] KIND_VEL    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACC    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ALIM   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_VLIM   = 3'd5;

    // Joint modes
    localparam logic [MODE_W-1:0] MODE_ANGLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VELO  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ACCEL = 2'd2;
    // Never written; a tick in this mode changes nothing
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    localparam logic [DT_W-1:0] MS_PER_S = 10'd1000;

    // Wide intermediate: product of a 33-bit value and 1000 or dt
    localparam int WIDE_W = 44;

endpackage

@@ rtl/jmi_muldiv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmi_muldiv: bit-serial multiply then divide
// Computes trunc(a * m / d) for signed a, unsigned 10-bit m and d, one bit a
// cycle: shift-add multiply over m, then restoring divide over the quotient.
// ----------------------------------------------------------------------------
module jmi_muldiv (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [jmi_pkg::VAL_W:0] a,      // 33-bit signed operand
    input  logic [jmi_pkg::DT_W-1:0]      m,
    input  logic [jmi_pkg::DT_W-1:0]      d,
    output logic                          done,
    output logic signed [jmi_pkg::WIDE_W-1:0] q
);

    localparam int W  = jmi_pkg::WIDE_W;
    localparam int DW = jmi_pkg::DT_W;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [W-1:0]     mcand_reg, mcand_next;  // magnitude, shifted left
    logic [DW-1:0]    mult_reg, mult_next;    // shifted right
    logic [W-1:0]     acc_reg, acc_next;      // product, then quotient bits
    logic [DW:0]      rem_reg, rem_next;
    logic [DW-1:0]    dvs_reg, dvs_next;
    logic             done_reg, done_next;
    logic [DW:0]      trial;
    logic [W-1:0]     a_mag;

    assign a_mag = a[jmi_pkg::VAL_W] ? W'(-{{(W-jmi_pkg::VAL_W-1){a[jmi_pkg::VAL_W]}}, a})
                                     : W'({{(W-jmi_pkg::VAL_W-1){1'b0}}, a});
    assign trial = {rem_reg[DW-1:0], acc_reg[W-1]} - {1'b0, dvs_reg};

    // Step the multiply, then the divide
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    neg_next   = a[jmi_pkg::VAL_W];
                    mcand_next = a_mag;
                    mult_next  = m;
                    dvs_next   = d;
                    acc_next   = '0;
                    cnt_next   = 6'(DW);
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mult_reg[0]) acc_next = acc_reg + mcand_reg;
                mcand_next = mcand_reg << 1;
                mult_next  = mult_reg >> 1;
                cnt_next   = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    rem_next   = '0;
                    cnt_next   = 6'(W);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!trial[DW]) begin
                    rem_next = trial;
                    acc_next = {acc_reg[W-2:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[DW-1:0], acc_reg[W-1]};
                    acc_next = {acc_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
    end

    assign done = done_reg;
    assign q    = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);

endmodule

@@ rtl/joint_motion_integrator.sv @@
`timescale 1ns / 1ps
// Set, load, read and rejected requests pass through the dispatch, finish and
// output states before m_tvalid rises; a tick is bound by the bit-serial muldiv
// unit (10 multiply and 44 divide steps per pass), with one pass in angle and
// velocity mode and two in acceleration mode. One request is in flight at a time;
// the next is accepted the cycle after the result is taken.
// Reset (aresetn low, synchronous): joint state zero, angle mode, joint_count 8.
// ----------------------------------------------------------------------------
// joint_motion_integrator: per-joint angle/velocity/acceleration integrator
// Stores joint targets and limits, integrates on tick, issues clamped angles.
// ----------------------------------------------------------------------------
module joint_motion_integrator #(
    parameter int MAX_JOINTS = jmi_pkg::MAX_JOINTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wen,
    input  logic [3:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata from bit 0: joint[2:0], value[34:3], upper_value[66:35],
    // measured_angle[98:67], elapsed_ms[108:99], zero fill to 112
    input  logic [111:0] s_tdata,
    input  logic [2:0]   s_tuser,  // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata from bit 0: angle_command[31:0], velocity_out[63:32],
    // accel_out[95:64]
    output logic [95:0]  m_tdata,
    output logic [1:0]   m_tuser   // angle_valid[0], status[1]
);

    localparam int VW = jmi_pkg::VAL_W;
    localparam int WW = jmi_pkg::WIDE_W;
    localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DISP  = 3'd1;
    localparam logic [2:0] ST_ACCW  = 3'd2;
    localparam logic [2:0] ST_POSS  = 3'd3;
    localparam logic [2:0] ST_POSW  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [3:0] count_reg;

    logic [jmi_pkg::MODE_W-1:0] mode_reg [MAX_JOINTS];
    logic signed [VW-1:0] tgt_reg [MAX_JOINTS];
    logic signed [VW-1:0] vel_reg [MAX_JOINTS];
    logic signed [VW-1:0] acc_reg [MAX_JOINTS];
    logic signed [VW-1:0] amin_reg [MAX_JOINTS];
    logic signed [VW-1:0] amax_reg [MAX_JOINTS];
    logic signed [VW-1:0] vmin_reg [MAX_JOINTS];
    logic signed [VW-1:0] vmax_reg [MAX_JOINTS];

    // Captured request
    logic [2:0]           kind_reg;
    logic [JW-1:0]        j_reg;
    logic                 rej_reg;
    logic signed [VW-1:0] val_reg, upr_reg, meas_reg;
    logic [jmi_pkg::DT_W-1:0] dt_reg;

    // Output register
    logic                 ov_reg;
    logic [95:0]          od_reg;
    logic [1:0]           ou_reg;

    // Muldiv
    logic                 md_start;
    logic signed [VW:0]   md_a;
    logic [jmi_pkg::DT_W-1:0] md_m, md_d;
    logic                 md_done;
    logic signed [WW-1:0] md_q;

    logic [jmi_pkg::DT_W-1:0] dt_in;
    logic [3:0]           lim;
    logic [JW-1:0]        jn;
    logic signed [VW-1:0] vnew;
    logic signed [WW-1:0] sum_w;
    logic signed [VW-1:0] vsat, clamp_v, clamp_o;
    logic signed [WW-1:0] clamp_in;
    logic signed [VW-1:0] lo_s, hi_s;

    assign s_tready = (state_reg == ST_IDLE) && !ov_reg;
    assign dt_in = (s_tdata[108:99] == '0) ? 10'd1 : s_tdata[108:99];
    assign lim   = (32'(count_reg) > MAX_JOINTS) ? 4'(MAX_JOINTS) : count_reg;
    assign jn    = JW'(s_tdata[2:0]);

    jmi_muldiv u_md (
        .aclk(aclk), .aresetn(aresetn), .start(md_start), .a(md_a),
        .m(md_m), .d(md_d), .done(md_done), .q(md_q)
    );

    // Select operands for the serial unit
    always_comb begin
        md_start = 1'b0;
        md_a     = '0;
        md_m     = dt_reg;
        md_d     = jmi_pkg::MS_PER_S;
        if (state_reg == ST_DISP && kind_reg == jmi_pkg::KIND_TICK) begin
            md_start = !rej_reg && (mode_reg[j_reg] != jmi_pkg::MODE_NONE);
            priority if (mode_reg[j_reg] == jmi_pkg::MODE_ANGLE) begin
                md_a = (VW+1)'(tgt_reg[j_reg]) - (VW+1)'(meas_reg);
                md_m = jmi_pkg::MS_PER_S;
                md_d = dt_reg;
            end else if (mode_reg[j_reg] == jmi_pkg::MODE_ACCEL) begin
                md_a = (VW+1)'(acc_reg[j_reg]);
            end else begin
                md_a = (VW+1)'(vel_reg[j_reg]);
            end
        end else if (state_reg == ST_POSS) begin
            md_start = 1'b1;
            md_a     = (VW+1)'(vel_reg[j_reg]);
        end
    end

    // Saturation and clamp helpers
    assign vsat = (md_q > WW'(64'sd2147483647)) ? 32'sh7fffffff :
                  (md_q < -WW'(64'sd2147483648)) ? 32'sh80000000 : VW'(md_q);
    always_comb begin
        if (state_reg == ST_ACCW) begin
            clamp_in = WW'(vel_reg[j_reg]) + md_q;
            lo_s = vmin_reg[j_reg];
            hi_s = vmax_reg[j_reg];
        end else if (state_reg == ST_POSW) begin
            clamp_in = WW'(meas_reg) + md_q;
            lo_s = amin_reg[j_reg];
            hi_s = amax_reg[j_reg];
        end else if (kind_reg == jmi_pkg::KIND_VEL) begin
            clamp_in = WW'(val_reg);
            lo_s = vmin_reg[j_reg];
            hi_s = vmax_reg[j_reg];
        end else begin
            clamp_in = WW'(tgt_reg[j_reg]);
            lo_s = amin_reg[j_reg];
            hi_s = amax_reg[j_reg];
        end
    end
    assign sum_w    = (clamp_in < WW'(lo_s)) ? WW'(lo_s) : clamp_in;
    assign clamp_o  = (sum_w > WW'(hi_s)) ? hi_s : VW'(sum_w);
    assign clamp_v  = clamp_o;
    assign vnew     = vel_reg[j_reg];

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid && s_tready) state_next = ST_DISP;
            ST_DISP: begin
                if (rej_reg || kind_reg != jmi_pkg::KIND_TICK ||
                    mode_reg[j_reg] == jmi_pkg::MODE_NONE)
                    state_next = ST_FIN;
                else if (mode_reg[j_reg] == jmi_pkg::MODE_ACCEL) state_next = ST_ACCW;
                else state_next = ST_POSW;
            end
            ST_ACCW: if (md_done) state_next = ST_POSS;
            ST_POSS: state_next = ST_POSW;
            ST_POSW: if (md_done) state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= 4'd8;
            ov_reg    <= 1'b0;
            for (int i = 0; i < MAX_JOINTS; i++) begin
                mode_reg[i] <= jmi_pkg::MODE_ANGLE;
                tgt_reg[i]  <= '0;
                vel_reg[i]  <= '0;
                acc_reg[i]  <= '0;
                amin_reg[i] <= '0;
                amax_reg[i] <= '0;
                vmin_reg[i] <= '0;
                vmax_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wen) count_reg <= cfg_wdata;
            if (m_tvalid && m_tready) ov_reg <= 1'b0;
            // Capture request
            if (state_reg == ST_IDLE && s_tvalid && s_tready) begin
                kind_reg <= s_tuser;
                j_reg    <= jn;
                rej_reg  <= ({1'b0, s_tdata[2:0]} >= lim) ||
                            (32'(s_tdata[2:0]) >= 32'(MAX_JOINTS));
                val_reg  <= s_tdata[34:3];
                upr_reg  <= s_tdata[66:35];
                meas_reg <= s_tdata[98:67];
                dt_reg   <= dt_in;
                ou_reg   <= '0;
            end
            // Apply set requests and the angle-mode tick
            if (state_reg == ST_DISP && !rej_reg) begin
                unique case (kind_reg)
                    jmi_pkg::KIND_TICK: if (mode_reg[j_reg] == jmi_pkg::MODE_ANGLE)
                        ou_reg[0] <= 1'b1;
                    jmi_pkg::KIND_TARGET: begin
                        tgt_reg[j_reg]  <= val_reg;
                        mode_reg[j_reg] <= jmi_pkg::MODE_ANGLE;
                    end
                    jmi_pkg::KIND_VEL: begin
                        vel_reg[j_reg]  <= clamp_v;
                        mode_reg[j_reg] <= jmi_pkg::MODE_VELO;
                    end
                    jmi_pkg::KIND_ACC: begin
                        acc_reg[j_reg]  <= val_reg;
                        mode_reg[j_reg] <= jmi_pkg::MODE_ACCEL;
                    end
                    jmi_pkg::KIND_ALIM: begin
                        amin_reg[j_reg] <= val_reg;
                        amax_reg[j_reg] <= upr_reg;
                    end
                    jmi_pkg::KIND_VLIM: begin
                        vmin_reg[j_reg] <= val_reg;
                        vmax_reg[j_reg] <= upr_reg;
                    end
                    default: ;
                endcase
                if (kind_reg == jmi_pkg::KIND_TICK && mode_reg[j_reg] == jmi_pkg::MODE_ANGLE)
                    od_reg[31:0] <= clamp_v;
                else
                    od_reg[31:0] <= '0;
            end
            if (state_reg == ST_ACCW && md_done) vel_reg[j_reg] <= clamp_v;
            if (state_reg == ST_POSW && md_done) begin
                if (mode_reg[j_reg] == jmi_pkg::MODE_ANGLE) begin
                    vel_reg[j_reg] <= vsat;
                end else begin
                    tgt_reg[j_reg] <= clamp_v;
                    od_reg[31:0]   <= clamp_v;
                    ou_reg[0]      <= 1'b1;
                end
            end
            // Present result
            if (state_reg == ST_OUT) begin
                ov_reg <= 1'b1;
                if (rej_reg) begin
                    od_reg <= '0;
                    ou_reg <= 2'b10;
                end else begin
                    od_reg[63:32] <= vnew;
                    od_reg[95:64] <= acc_reg[j_reg];
                end
            end
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ou_reg;

    // Checks
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("accept while busy");
    a_out_after_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |=> m_tvalid) else $error("result not raised");
    a_rej_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && m_tdata == '0))
        else $error("rejected result not zero");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the joint motion integrator
// Drives set, limit, read and tick requests with random bursts and stalls,
// predicts every response from a local joint state copy and compares fields.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [jmi_pkg::KIND_W-1:0] KIND_READ = 3'd6;
    localparam logic [jmi_pkg::KIND_W-1:0] KIND_ALT  = 3'd7;

    typedef struct packed {
        logic [31:0] angle_cmd;
        logic        angle_ok;
        logic [31:0] vel;
        logic [31:0] acc;
        logic        rejected;
    } motion_resp_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wen = 1'b0;
    logic [3:0]   cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;

    // predicted joint state
    logic [1:0]   mode_q [8];
    logic signed [31:0] tgt_q [8], vel_q [8], acc_q [8];
    logic signed [31:0] amin_q [8], amax_q [8], vmin_q [8], vmax_q [8];
    logic [3:0]   count_q;

    motion_resp_t pending_resp [$];
    int           mismatches = 0;
    int           burst_left = 0;

    always #10 aclk = ~aclk;

    joint_motion_integrator dut (.*);

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %h expected %h", what, got, exp);
        mismatches++;
    endtask

    function automatic logic signed [63:0] clamp(input logic signed [63:0] x,
            input logic signed [31:0] lo, input logic signed [31:0] hi);
        if (x < 64'(lo)) x = 64'(lo);
        if (x > 64'(hi)) x = 64'(hi);
        return x;
    endfunction

    // advance the local state by one request and return the response
    function automatic motion_resp_t predict_motion(input logic [2:0] kind,
            input logic [2:0] j, input logic signed [31:0] val,
            input logic signed [31:0] up, input logic signed [31:0] meas,
            input logic [9:0] dt_in);
        motion_resp_t r;
        logic signed [63:0] dt, v, c, q;
        int lim;
        r = '0;
        dt = (dt_in == 0) ? 64'sd1 : $signed({54'd0, dt_in});
        lim = (count_q > 8) ? 8 : int'(count_q);
        if (int'(j) >= lim) begin
            r.rejected = 1'b1;
            return r;
        end
        case (kind)
            jmi_pkg::KIND_TICK: begin
                if (mode_q[j] == jmi_pkg::MODE_ANGLE) begin
                    q = ((64'(tgt_q[j]) - 64'(meas)) * 64'sd1000) / dt;
                    vel_q[j] = 32'(clamp(q, 32'sh80000000, 32'sh7fffffff));
                    r.angle_cmd = 32'(clamp(64'(tgt_q[j]), amin_q[j], amax_q[j]));
                    r.angle_ok = 1'b1;
                end else if (mode_q[j] == jmi_pkg::MODE_VELO ||
                             mode_q[j] == jmi_pkg::MODE_ACCEL) begin
                    v = 64'(vel_q[j]);
                    if (mode_q[j] == jmi_pkg::MODE_ACCEL) begin
                        v = v + (64'(acc_q[j]) * dt) / 64'sd1000;
                        v = clamp(v, vmin_q[j], vmax_q[j]);
                        vel_q[j] = 32'(v);
                    end
                    c = 64'(meas) + (v * dt) / 64'sd1000;
                    c = clamp(c, amin_q[j], amax_q[j]);
                    tgt_q[j] = 32'(c);
                    r.angle_cmd = 32'(c);
                    r.angle_ok = 1'b1;
                end
            end
            jmi_pkg::KIND_TARGET: begin
                tgt_q[j] = val;
                mode_q[j] = jmi_pkg::MODE_ANGLE;
            end
            jmi_pkg::KIND_VEL: begin
                vel_q[j] = 32'(clamp(64'(val), vmin_q[j], vmax_q[j]));
                mode_q[j] = jmi_pkg::MODE_VELO;
            end
            jmi_pkg::KIND_ACC: begin
                acc_q[j] = val;
                mode_q[j] = jmi_pkg::MODE_ACCEL;
            end
            jmi_pkg::KIND_ALIM: begin amin_q[j] = val; amax_q[j] = up; end
            jmi_pkg::KIND_VLIM: begin vmin_q[j] = val; vmax_q[j] = up; end
            default: ;
        endcase
        r.vel = vel_q[j];
        r.acc = acc_q[j];
        return r;
    endfunction

    // send one request in bursts with random gaps
    task automatic send_request(input logic [2:0] kind, input logic [2:0] j,
            input logic [31:0] val, input logic [31:0] up, input logic [31:0] meas,
            input logic [9:0] dt);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {3'd0, dt, meas, up, val, j};
        pending_resp.push_back(predict_motion(kind, j, val, up, meas, dt));
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_wait();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_resp.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    task automatic write_count(input logic [3:0] n);
        cfg_wen <= 1'b1;
        cfg_wdata <= n;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        count_q = n;
    endtask

    // receiver stall pattern, with stall-free stretches
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(posedge aclk);
            phase++;
            if ((phase / 200) % 3 == 0) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // compare each accepted response with the oldest prediction
    always @(posedge aclk) begin
        motion_resp_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_resp.size() == 0) begin
                $display("response with no request outstanding");
                mismatches++;
            end else begin
                e = pending_resp.pop_front();
                if (m_tdata[31:0] !== e.angle_cmd)
                    report("angle_command", m_tdata[31:0], e.angle_cmd);
                if (m_tuser[0] !== e.angle_ok)
                    report("angle_valid", 32'(m_tuser[0]), 32'(e.angle_ok));
                if (m_tdata[63:32] !== e.vel) report("velocity", m_tdata[63:32], e.vel);
                if (m_tdata[95:64] !== e.acc) report("accel", m_tdata[95:64], e.acc);
                if (m_tuser[1] !== e.rejected)
                    report("status", 32'(m_tuser[1]), 32'(e.rejected));
            end
        end
    end

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        // extremes and each special case
        send_request(jmi_pkg::KIND_TICK, 0, 0, 0, 32'h80000000, 10'd0);
        send_request(jmi_pkg::KIND_TARGET, 0, 32'h7fffffff, 0, 0, 1);
        send_request(jmi_pkg::KIND_TICK, 0, 0, 0, 32'h80000000, 10'd1);
        send_request(jmi_pkg::KIND_ALIM, 0, 32'hffff0000, 32'h00010000, 0, 1);
        send_request(jmi_pkg::KIND_TICK, 0, 0, 0, 32'h00001234, 10'd1000);
        send_request(jmi_pkg::KIND_ALIM, 1, 32'h00050000, 32'h00010000, 0, 1);
        send_request(jmi_pkg::KIND_TICK, 1, 0, 0, 0, 10'd1023);
        send_request(jmi_pkg::KIND_VLIM, 1, 32'h80000000, 32'h7fffffff, 0, 1);
        send_request(jmi_pkg::KIND_VEL, 1, 32'h7fffffff, 0, 0, 1);
        send_request(jmi_pkg::KIND_ALIM, 1, 32'h80000000, 32'h7fffffff, 0, 1);
        send_request(jmi_pkg::KIND_TICK, 1, 0, 0, 32'h7fffffff, 10'd1000);
        send_request(jmi_pkg::KIND_ACC, 2, 32'h80000000, 0, 0, 1);
        send_request(jmi_pkg::KIND_VLIM, 2, 32'hfff00000, 32'h00100000, 0, 1);
        send_request(jmi_pkg::KIND_ALIM, 2, 32'h80000000, 32'h7fffffff, 0, 1);
        send_request(jmi_pkg::KIND_TICK, 2, 0, 0, 32'h80000000, 10'd1000);
        send_request(KIND_READ, 2, 32'hffffffff, 32'hffffffff, 32'hffffffff, 10'h3ff);
        send_request(KIND_ALT, 7, 0, 0, 0, 1);
        send_request(jmi_pkg::KIND_VEL, 7, 32'h00020000, 0, 0, 1);
        idle_wait();
    endtask

    task automatic test_random(input int n);
        logic [2:0] k;
        int kr;
        repeat (n) begin
            kr = $urandom_range(0, 9);
            k = (kr > 7) ? jmi_pkg::KIND_TICK : 3'(kr);
            send_request(k, 3'($urandom_range(0, 7)), rand_q(), rand_q(), rand_q(),
                         ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                                     : 10'($urandom_range(1, 50)));
        end
        idle_wait();
    endtask

    task automatic test_joint_count();
        write_count(4'd0);
        test_random(40);
        write_count(4'd15);
        test_random(60);
        write_count(4'd1);
        test_random(80);
        write_count(4'd5);
        test_random(100);
        write_count(4'd8);
    endtask

    initial begin
        for (int i = 0; i < 8; i++) begin
            mode_q[i] = jmi_pkg::MODE_ANGLE;
            tgt_q[i] = 0; vel_q[i] = 0; acc_q[i] = 0;
            amin_q[i] = 0; amax_q[i] = 0; vmin_q[i] = 0; vmax_q[i] = 0;
        end
        count_q = 4'd8;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_directed();
        test_joint_count();
        test_random(800);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pending_resp.size() == 0) $display("tb_top OK");
        else $display("tb_top NOT OK");
        $finish;
    end

    // watchdog
    initial begin
        #40ms;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule

@@ files.f @@
rtl/jmi_pkg.sv
rtl/jmi_muldiv.sv
rtl/joint_motion_integrator.sv
dv/tb_top.sv
